/* rtl/ddpc_pkg.sv */
// shared types, constants and register map of the differential drive controller
package ddpc_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int PWM_W  = 9;

  localparam int PWM_MAX = 255;
  localparam int PWM_MIN = -255;

  localparam logic CMD_STRAIGHT = 1'b0;
  localparam logic CMD_ROTATE   = 1'b1;

  typedef enum logic [2:0] {
    REG_BASE_SPEED      = 3'd0,
    REG_KP_GAIN         = 3'd1,
    REG_DIST_GAIN       = 3'd2,
    REG_ANGLE_GAIN      = 3'd3,
    REG_ARRIVE_MARGIN   = 3'd4,
    REG_UPDATE_INTERVAL = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  base_speed;
    logic [15:0] kp_gain;
    logic [19:0] dist_gain;
    logic [19:0] angle_gain;
    logic [15:0] arrive_margin;
    logic [15:0] update_interval;
  } cfg_t;

  localparam logic [7:0]  RST_BASE_SPEED      = 8'd200;
  localparam logic [15:0] RST_KP_GAIN         = 16'd256;
  localparam logic [19:0] RST_DIST_GAIN       = 20'd256;
  localparam logic [19:0] RST_ANGLE_GAIN      = 20'd256;
  localparam logic [15:0] RST_ARRIVE_MARGIN   = 16'd20;
  localparam logic [15:0] RST_UPDATE_INTERVAL = 16'd10;

endpackage

/* rtl/ddpc_in_if.sv */
// request channel: valid, ready and the control request fields
interface ddpc_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [7:0]         call_step;
  logic signed [15:0] target;
  logic signed [23:0] ticks_left;
  logic signed [23:0] ticks_right;
  logic [31:0]        now_ms;

  modport source (
    output valid, cmd, call_step, target, ticks_left, ticks_right, now_ms,
    input  ready
  );
  modport sink (
    input  valid, cmd, call_step, target, ticks_left, ticks_right, now_ms,
    output ready
  );
endinterface

/* rtl/ddpc_out_if.sv */
// result channel: valid, ready and the control result fields
interface ddpc_out_if;
  logic              valid;
  logic              ready;
  logic              updated;
  logic signed [8:0] pwm_right;
  logic signed [8:0] pwm_left;
  logic              motor_stop;
  logic              clear_encoders;
  logic [7:0]        current_step;
  logic [31:0]       last_time;

  modport source (
    output valid, updated, pwm_right, pwm_left, motor_stop, clear_encoders,
           current_step, last_time,
    input  ready
  );
  modport sink (
    input  valid, updated, pwm_right, pwm_left, motor_stop, clear_encoders,
           current_step, last_time,
    output ready
  );
endinterface

/* rtl/diff_drive_p_controller_core.sv */
// top level of the differential drive proportional heading controller
//
// in_ch carries control requests (move kind, step, target, both encoder
// counts, time); out_ch returns one result item per request: update flag,
// saturated pwm for both wheels, stop and encoder clear flags, step counter
// and time of the latest update. Registers are written over the apb port.
// Each request passes the input register, the product register and the
// result register before its result shows on out_ch. Throughput is one
// request per cycle while out_ch takes results; the gain and target
// multiplies sit in the first stage, the step and interval check and the
// state update in the second.
// A result waiting on a stalled out_ch holds; the two inner stages keep
// filling, and in_ch.ready drops once all three registers are full.
// Reset clears the pipeline, the step counter and the last update time,
// and loads the register defaults.
module diff_drive_p_controller_core (
  input  logic                        clk,
  input  logic                        rst,
  ddpc_in_if.sink                     in_ch,
  ddpc_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddpc_pkg::ADDR_W-1:0] paddr,
  input  logic [ddpc_pkg::DATA_W-1:0] pwdata,
  output logic [ddpc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import ddpc_pkg::*;

  function automatic logic signed [PWM_W-1:0] sat_pwm(input logic signed [35:0] v);
    if (v > 36'(PWM_MAX)) begin
      return PWM_W'(PWM_MAX);
    end else if (v < 36'(PWM_MIN)) begin
      return PWM_W'(PWM_MIN);
    end
    return v[PWM_W-1:0];
  endfunction

  cfg_t cfg;

  ddpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake
  logic in_fire, adv2, adv_out;
  logic s1_valid, s2_valid, o_valid;

  // stage 1: input register
  logic               s1_cmd;
  logic [7:0]         s1_step;
  logic signed [15:0] s1_target;
  logic signed [23:0] s1_left;
  logic signed [23:0] s1_right;
  logic [31:0]        s1_now;

  // stage 2: product register
  logic               s2_cmd;
  logic [7:0]         s2_step;
  logic               s2_neg;
  logic [31:0]        s2_now;
  logic signed [33:0] s2_corr;
  logic signed [36:0] s2_scaled;
  logic signed [23:0] s2_left;
  logic signed [23:0] s2_right;

  // state
  logic [7:0]  step_counter, step_counter_next;
  logic [31:0] last_update_time, last_update_time_next;

  // output register
  logic              o_updated;
  logic signed [8:0] o_pwm_right, o_pwm_left;
  logic              o_stop;
  logic [7:0]        o_step;
  logic [31:0]       o_time;

  assign adv_out     = s2_valid & (~o_valid | out_ch.ready);
  assign adv2        = s1_valid & (~s2_valid | adv_out);
  assign in_ch.ready = ~s1_valid | adv2;
  assign in_fire     = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      s1_valid <= in_fire | (s1_valid & ~adv2);
      s2_valid <= adv2 | (s2_valid & ~adv_out);
      o_valid  <= adv_out | (o_valid & ~out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd    <= in_ch.cmd;
      s1_step   <= in_ch.call_step;
      s1_target <= in_ch.target;
      s1_left   <= in_ch.ticks_left;
      s1_right  <= in_ch.ticks_right;
      s1_now    <= in_ch.now_ms;
    end
  end

  // stage 1 logic: tick error, gain products
  logic signed [24:0] err;
  logic signed [41:0] prod, prod_rnd;
  logic [19:0]        gain;
  logic signed [36:0] scaled;

  always_comb begin
    if (s1_cmd == CMD_ROTATE) begin
      err  = 25'(s1_left) + 25'(s1_right);
      gain = cfg.angle_gain;
    end else begin
      err  = 25'(s1_left) - 25'(s1_right);
      gain = cfg.dist_gain;
    end
    prod     = $signed({1'b0, cfg.kp_gain}) * err;
    // truncate toward zero
    prod_rnd = prod + (prod[41] ? 42'sd255 : 42'sd0);
    scaled   = s1_target * $signed({1'b0, gain});
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_cmd    <= s1_cmd;
      s2_step   <= s1_step;
      s2_neg    <= s1_target[15];
      s2_now    <= s1_now;
      s2_corr   <= prod_rnd[41:8];
      s2_scaled <= scaled;
      s2_left   <= s1_left;
      s2_right  <= s1_right;
    end
  end

  // stage 2 logic: pwm, arrival, step and interval check
  logic signed [35:0] bs, corr, pr_raw, pl_raw;
  logic signed [38:0] sc, tl, tr, d_l, d_r, marg;
  logic               arrive, fire;
  logic [31:0]        elapsed;

  always_comb begin
    corr = 36'(s2_corr);
    bs   = s2_neg ? -$signed({28'd0, cfg.base_speed}) : $signed({28'd0, cfg.base_speed});
    sc   = 39'(s2_scaled);
    tl   = 39'($signed({s2_left, 8'h00}));
    tr   = 39'($signed({s2_right, 8'h00}));
    marg = $signed(39'({cfg.arrive_margin, 8'h00}));
    if (s2_cmd == CMD_ROTATE) begin
      pr_raw = bs - corr;
      pl_raw = -bs - corr;
      d_l    = sc + tl;
    end else begin
      pr_raw = bs + corr;
      pl_raw = bs - corr;
      d_l    = sc - tl;
    end
    d_r     = sc - tr;
    arrive  = (d_l > -marg) && (d_l < marg) && (d_r > -marg) && (d_r < marg);
    elapsed = s2_now - last_update_time;
    fire    = (s2_step == step_counter) && (elapsed >= 32'(cfg.update_interval));

    step_counter_next     = step_counter;
    last_update_time_next = last_update_time;
    if (fire) begin
      last_update_time_next = s2_now;
      if (arrive) begin
        step_counter_next = step_counter + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter     <= '0;
      last_update_time <= '0;
    end else if (adv_out) begin
      step_counter     <= step_counter_next;
      last_update_time <= last_update_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      o_updated   <= fire;
      o_stop      <= fire & arrive;
      o_pwm_right <= (fire & ~arrive) ? sat_pwm(pr_raw) : '0;
      o_pwm_left  <= (fire & ~arrive) ? sat_pwm(pl_raw) : '0;
      o_step      <= step_counter_next;
      o_time      <= last_update_time_next;
    end
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.updated        = o_updated;
  assign out_ch.pwm_right      = o_pwm_right;
  assign out_ch.pwm_left       = o_pwm_left;
  assign out_ch.motor_stop     = o_stop;
  assign out_ch.clear_encoders = o_stop;
  assign out_ch.current_step   = o_step;
  assign out_ch.last_time      = o_time;

endmodule

/* rtl/ddpc_cfg_regs.sv */
// apb configuration register file of the differential drive controller
module ddpc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddpc_pkg::ADDR_W-1:0] paddr,
  input  logic [ddpc_pkg::DATA_W-1:0] pwdata,
  output logic [ddpc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output ddpc_pkg::cfg_t              cfg
);
  import ddpc_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_speed      <= RST_BASE_SPEED;
      cfg.kp_gain         <= RST_KP_GAIN;
      cfg.dist_gain       <= RST_DIST_GAIN;
      cfg.angle_gain      <= RST_ANGLE_GAIN;
      cfg.arrive_margin   <= RST_ARRIVE_MARGIN;
      cfg.update_interval <= RST_UPDATE_INTERVAL;
    end else if (wr_en) begin
      case (idx)
        REG_BASE_SPEED:      cfg.base_speed      <= pwdata[7:0];
        REG_KP_GAIN:         cfg.kp_gain         <= pwdata[15:0];
        REG_DIST_GAIN:       cfg.dist_gain       <= pwdata[19:0];
        REG_ANGLE_GAIN:      cfg.angle_gain      <= pwdata[19:0];
        REG_ARRIVE_MARGIN:   cfg.arrive_margin   <= pwdata[15:0];
        REG_UPDATE_INTERVAL: cfg.update_interval <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE_SPEED:      prdata = DATA_W'(cfg.base_speed);
      REG_KP_GAIN:         prdata = DATA_W'(cfg.kp_gain);
      REG_DIST_GAIN:       prdata = DATA_W'(cfg.dist_gain);
      REG_ANGLE_GAIN:      prdata = DATA_W'(cfg.angle_gain);
      REG_ARRIVE_MARGIN:   prdata = DATA_W'(cfg.arrive_margin);
      REG_UPDATE_INTERVAL: prdata = DATA_W'(cfg.update_interval);
      default:             prdata = '0;
    endcase
  end

endmodule

/* rtl/ddpc_checker.sv */
// port level checks of the differential drive controller, bound to the top level
module ddpc_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              updated,
  input logic signed [8:0] pwm_right,
  input logic signed [8:0] pwm_left,
  input logic              motor_stop,
  input logic              clear_encoders,
  input logic [7:0]        current_step
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pwm_right) && $stable(pwm_left)
      && $stable(current_step) && $stable(updated))
    else $error("stalled result changed");

  // no update means no drive and no stop
  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !updated |-> pwm_right == 9'sd0 && pwm_left == 9'sd0 && !motor_stop)
    else $error("drive without update");

  // arrival stops both motors and clears the encoders
  a_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_stop |-> updated && clear_encoders
      && pwm_right == 9'sd0 && pwm_left == 9'sd0)
    else $error("arrival result inconsistent");

  // saturation keeps pwm off the most negative code; stop and encoder clear agree
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pwm_right != -9'sd256 && pwm_left != -9'sd256
      && motor_stop == clear_encoders)
    else $error("pwm out of range");

endmodule

bind diff_drive_p_controller_core ddpc_checker u_ddpc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .updated        (out_ch.updated),
  .pwm_right      (out_ch.pwm_right),
  .pwm_left       (out_ch.pwm_left),
  .motor_stop     (out_ch.motor_stop),
  .clear_encoders (out_ch.clear_encoders),
  .current_step   (out_ch.current_step)
);
